### sv/vde_pkg.sv
`default_nettype none
package vde_pkg;

    // sizes fixed by the item fields and registers
    localparam int DIM_DEFAULT = 1024;
    localparam int LEN_W       = 11;
    localparam int ELEM_W      = 16;
    localparam int TERM_W      = 34;
    localparam int ACC_W       = 44;
    localparam int CNUM_W      = 16;
    localparam int METRIC_W    = 2;
    localparam int CFG_IDX_W   = 1;

    // output queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;
    localparam int OQ_CNT_W = 4;

    // register reset values
    localparam logic [LEN_W-1:0]    LEN_RESET    = 11'd1024;
    localparam logic [METRIC_W-1:0] METRIC_RESET = 2'd0;

    // 1.0 in product scale
    localparam logic signed [ACC_W-1:0] ONE_PS = 44'sh000_4000_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METRIC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VLEN   = 1'd1;

    // metric codes, the unused code behaves as cosine
    localparam logic [METRIC_W-1:0] METRIC_COSINE = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_L2     = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_DOT    = 2'd2;

    // item kinds
    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_CAND  = 1'b1;

    // control of one item on its way into the datapath
    typedef struct packed {
        logic              valid;
        logic              clr;
        logic              last;
        logic [CNUM_W-1:0] cnum;
    } t_s1_ctl;

    // a finished distance
    typedef struct packed {
        logic signed [ACC_W-1:0] distance;
        logic [CNUM_W-1:0]       cnum;
    } t_res;

    // results still inside the datapath
    typedef struct packed {
        logic s2_pend;
        logic s3_pend;
    } t_mac_status;

endpackage
`default_nettype wire

### sv/vde_ram.sv
`default_nettype none
module vde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### sv/vde_mac.sv
`default_nettype none
module vde_mac (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [vde_pkg::METRIC_W-1:0]    i_metric,
    input  wire vde_pkg::t_s1_ctl                i_s1,
    input  wire logic signed [vde_pkg::ELEM_W-1:0] i_elem,
    input  wire logic signed [vde_pkg::ELEM_W-1:0] i_qdata,
    output logic                                 o_push_valid,
    output vde_pkg::t_res                        o_push_data,
    output vde_pkg::t_mac_status                 o_status
);
    import vde_pkg::*;

    logic signed [ELEM_W:0]   diff;
    logic signed [ELEM_W:0]   mul_a;
    logic signed [ELEM_W:0]   mul_b;
    logic signed [TERM_W-1:0] prod;

    t_s1_ctl                  r_s2;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  acc_sum;

    logic                     r_s3_valid;
    logic signed [ACC_W-1:0]  r_s3_sum;
    logic [CNUM_W-1:0]        r_s3_cnum;

    // product term: (q-c)^2 for l2, q*c otherwise
    always_comb begin
        diff = {i_qdata[ELEM_W-1], i_qdata} - {i_elem[ELEM_W-1], i_elem};
        if (i_metric == METRIC_L2) begin
            mul_a = diff;
            mul_b = diff;
        end else begin
            mul_a = {i_qdata[ELEM_W-1], i_qdata};
            mul_b = {i_elem[ELEM_W-1], i_elem};
        end
        prod = mul_a * mul_b;
    end

    // term register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= i_s1;
        end
        r_term <= prod;
    end

    assign acc_sum = r_acc + ACC_W'(r_term);

    // accumulator, cleared by a query load and after each finished candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2.valid & r_s2.last;
            if (r_s2.valid) begin
                if (r_s2.clr || r_s2.last) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_sum;
                end
            end
        end
        r_s3_sum  <= acc_sum;
        r_s3_cnum <= r_s2.cnum;
    end

    // final distance per metric
    always_comb begin
        o_push_data.cnum = r_s3_cnum;
        case (i_metric)
            METRIC_L2:  o_push_data.distance = r_s3_sum;
            METRIC_DOT: o_push_data.distance = -r_s3_sum;
            default:    o_push_data.distance = ONE_PS - r_s3_sum;
        endcase
    end

    assign o_push_valid     = r_s3_valid;
    assign o_status.s2_pend = r_s2.valid & r_s2.last;
    assign o_status.s3_pend = r_s3_valid;

endmodule
`default_nettype wire

### sv/vde_oq.sv
`default_nettype none
module vde_oq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire vde_pkg::t_res                 i_push_data,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic signed [vde_pkg::ACC_W-1:0]   o_distance,
    output logic [vde_pkg::CNUM_W-1:0]         o_candidate_number,
    output logic [vde_pkg::OQ_CNT_W-1:0]       o_count
);
    import vde_pkg::*;

    t_res                r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic [OQ_CNT_W-1:0] n_count;
    logic                pop;

    assign pop = o_out_valid & ~i_out_stall;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + OQ_CNT_W'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - OQ_CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OQ_PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_out_valid        = (r_count != '0);
    assign o_distance         = r_mem[r_rd_ptr].distance;
    assign o_candidate_number = r_mem[r_rd_ptr].cnum;
    assign o_count            = r_count;

endmodule
`default_nettype wire

### sv/vector_distance_engine_core.sv
`default_nettype none
// Scores candidate vectors against a stored query vector, one Q1.15 element per
// cycle. Kind 0 requests load the query store in order; kind 1 requests stream a
// candidate, and after vector_length elements one distance (cosine 1-dot,
// squared L2, or negated dot, in Q14.30) comes out with its candidate number.
// A new request is taken every cycle; the rate is set by the single query store
// read port and the one 17x17 multiplier per element. The last element of a
// candidate passes the first stage, the term and the result register, and up to
// eight finished distances then wait in an output queue; the input stalls only
// when that queue together with the distances still in flight would overflow.
module vector_distance_engine_core #(
    parameter int DIM = vde_pkg::DIM_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [vde_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [vde_pkg::LEN_W-1:0]         i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_kind,
    input  wire logic signed [vde_pkg::ELEM_W-1:0] i_element_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [vde_pkg::ACC_W-1:0]       o_distance,
    output logic [vde_pkg::CNUM_W-1:0]             o_candidate_number
);
    import vde_pkg::*;

    localparam int               IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [LEN_W-1:0] DIM_LEN = LEN_W'(DIM);

    logic [METRIC_W-1:0] r_metric;
    logic [LEN_W-1:0]    r_vlen;
    logic [LEN_W-1:0]    len_eff;
    logic [IDX_W-1:0]    r_query_idx;
    logic [IDX_W-1:0]    r_cand_idx;
    logic [CNUM_W-1:0]   r_cand_cnt;
    logic                q_wrap;
    logic                c_last;
    logic                accept;

    t_s1_ctl             r_s1;
    logic signed [ELEM_W-1:0] r_s1_elem;
    logic signed [ELEM_W-1:0] qdata;

    logic                push_valid;
    t_res                push_data;
    t_mac_status         mac_status;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [OQ_CNT_W-1:0] pend;

    // effective vector length
    always_comb begin
        if (r_vlen == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_vlen > DIM_LEN) begin
            len_eff = DIM_LEN;
        end else begin
            len_eff = r_vlen;
        end
    end

    assign q_wrap = (LEN_W'(r_query_idx) + LEN_W'(1)) >= len_eff;
    assign c_last = (LEN_W'(r_cand_idx) + LEN_W'(1)) >= len_eff;

    // stall when the queue plus distances in flight could overflow
    assign pend = oq_count + OQ_CNT_W'(r_s1.valid & r_s1.last)
                + OQ_CNT_W'(mac_status.s2_pend) + OQ_CNT_W'(mac_status.s3_pend);
    assign o_in_stall = (pend >= OQ_CNT_W'(OQ_DEPTH));
    assign accept     = i_in_valid & ~o_in_stall;

    // configuration registers and element indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric    <= METRIC_RESET;
            r_vlen      <= LEN_RESET;
            r_query_idx <= '0;
            r_cand_idx  <= '0;
            r_cand_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_METRIC: r_metric <= i_cfg_data[METRIC_W-1:0];
                    REG_VLEN:   r_vlen   <= i_cfg_data;
                    default:    r_vlen   <= r_vlen;
                endcase
            end
            if (accept) begin
                if (i_kind == KIND_QUERY) begin
                    r_query_idx <= q_wrap ? '0 : r_query_idx + IDX_W'(1);
                    r_cand_idx  <= '0;
                    r_cand_cnt  <= '0;
                end else begin
                    r_cand_idx <= c_last ? '0 : r_cand_idx + IDX_W'(1);
                    if (c_last) begin
                        r_cand_cnt <= r_cand_cnt + CNUM_W'(1);
                    end
                end
            end
        end
    end

    // first pipeline stage, aligned with the query store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1.valid <= accept;
            r_s1.clr   <= (i_kind == KIND_QUERY);
            r_s1.last  <= (i_kind == KIND_CAND) & c_last;
            r_s1.cnum  <= r_cand_cnt;
        end
        r_s1_elem <= i_element_value;
    end

    // query store
    vde_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DIM)
    ) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (accept & (i_kind == KIND_QUERY)),
        .i_waddr (r_query_idx),
        .i_wdata (i_element_value),
        .i_re    (accept & (i_kind == KIND_CAND)),
        .i_raddr (r_cand_idx),
        .o_rdata (qdata)
    );

    // multiply-accumulate and distance
    vde_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_metric     (r_metric),
        .i_s1         (r_s1),
        .i_elem       (r_s1_elem),
        .i_qdata      (qdata),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .o_status     (mac_status)
    );

    // output queue
    vde_oq u_oq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push_valid),
        .i_push_data        (push_data),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_distance         (o_distance),
        .o_candidate_number (o_candidate_number),
        .o_count            (oq_count)
    );

`ifndef SYNTH
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    a_query_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_QUERY) |=> (r_cand_idx == '0 && r_cand_cnt == '0))
        else $error("query load did not restart candidate tracking");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEN_W'(r_cand_idx) < DIM_LEN) && (LEN_W'(r_query_idx) < DIM_LEN))
        else $error("element index beyond store depth");
`endif

endmodule
`default_nettype wire
